// ===== design/rch_pkg.sv =====
`default_nettype none
package rch_pkg;

  localparam int CHANNELS         = 4;
  localparam int BINS_PER_CHANNEL = 256;
  localparam int COUNT_WIDTH      = 32;

  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 8;
  localparam int INDEX_W  = 10;
  localparam int OUT_W    = 32;

  localparam int BIN_TOTAL = CHANNELS * BINS_PER_CHANNEL;
  localparam int BIN_W     = $clog2(BIN_TOTAL);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAT_W     = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
  localparam int CMP_W     = ((BIN_W > INDEX_W) ? BIN_W : INDEX_W) + 1;

  typedef logic [KIND_W-1:0]      kind_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_W-1:0]       bin_t;
  typedef logic [CH_W-1:0]        chan_t;

  localparam kind_t KIND_SAMPLE = 2'd0;
  localparam kind_t KIND_READ   = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic active;
    bin_t addr;
  } clear_ctl_t;

endpackage
`default_nettype wire

// ===== design/rch_count_ram.sv =====
`default_nettype none
module rch_count_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/rch_clear_seq.sv =====
`default_nettype none
module rch_clear_seq
  import rch_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start_clear,
  output clear_ctl_t ctl
);

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  state_t state;
  bin_t   addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      addr  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start_clear) begin
            state <= ST_SWEEP;
            addr  <= '0;
          end
        end
        ST_SWEEP: begin
          addr <= addr + 1'b1;
          if (addr == BIN_W'(BIN_TOTAL - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ctl.active = (state == ST_SWEEP);
  assign ctl.addr   = addr;

endmodule
`default_nettype wire

// ===== design/rgba_channel_histogram.sv =====
`default_nettype none
// Per-channel histogram of interleaved RGBA bytes, counts held in one synchronous RAM.
// Sample and read items are taken one per cycle while busy is low; a read result is
// strobed on done for one cycle, registered through s1_valid and then done, and the
// receiver cannot stall it. A clear item holds busy high while the RAM is swept to
// zero. Reset is synchronous and starts the same sweep before any item is taken.
module rgba_channel_histogram
  import rch_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [INDEX_W-1:0]  bin_index,
  output logic                     done,
  output logic [OUT_W-1:0]         bin_count
);

  clear_ctl_t clr;
  logic       accept;
  chan_t      chan;
  chan_t      chan_next;

  logic [CMP_W-1:0] sample_bin_wide;
  logic [CMP_W-1:0] index_wide;
  logic             index_in_range;
  bin_t             rd_addr;
  count_t           rd_data;

  logic   s1_valid;
  logic   s1_is_sample;
  logic   s1_in_range;
  bin_t   s1_addr;
  logic   fwd_hit;
  count_t fwd_data;

  count_t             operand;
  count_t             new_count;
  logic [SAT_W-1:0]   operand_wide;
  logic [OUT_W-1:0]   count_sat;

  logic   we;
  bin_t   waddr;
  count_t wdata;

  assign busy   = clr.active;
  assign accept = start && !busy;

  assign chan_next = (chan == CH_W'(CHANNELS - 1)) ? '0 : chan + 1'b1;

  assign sample_bin_wide = CMP_W'(chan) * CMP_W'(BINS_PER_CHANNEL) + CMP_W'(sample);
  assign index_wide      = CMP_W'(bin_index);
  assign index_in_range  = index_wide < CMP_W'(BIN_TOTAL);
  assign rd_addr = (kind == KIND_SAMPLE) ? sample_bin_wide[BIN_W-1:0]
                                         : index_wide[BIN_W-1:0];

  assign operand   = fwd_hit ? fwd_data : rd_data;
  assign new_count = (operand == COUNT_MAX) ? operand : operand + 1'b1;

  assign operand_wide = SAT_W'(operand);
  assign count_sat = (operand_wide > SAT_W'({OUT_W{1'b1}})) ? '1
                                                             : operand_wide[OUT_W-1:0];

  assign we    = clr.active || (s1_valid && s1_is_sample);
  assign waddr = clr.active ? clr.addr : s1_addr;
  assign wdata = clr.active ? '0 : new_count;

  rch_count_ram #(
    .DEPTH(BIN_TOTAL),
    .WIDTH(COUNT_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  rch_clear_seq u_clear (
    .clk        (clk),
    .rst        (rst),
    .start_clear(accept && (kind == KIND_CLEAR)),
    .ctl        (clr)
  );

  // The write of the item in flight lands at the edge that reads the next item,
  // so a repeated bin takes its operand from the forwarded value.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan     <= '0;
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept && ((kind == KIND_SAMPLE) || (kind == KIND_READ));
      fwd_hit  <= s1_valid && s1_is_sample && (s1_addr == rd_addr);
      done     <= s1_valid && !s1_is_sample;
      if (accept && (kind == KIND_CLEAR)) begin
        chan <= '0;
      end else if (accept && (kind == KIND_SAMPLE)) begin
        chan <= chan_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_is_sample <= (kind == KIND_SAMPLE);
    s1_in_range  <= (kind == KIND_SAMPLE) || index_in_range;
    s1_addr      <= rd_addr;
    fwd_data     <= new_count;
    bin_count    <= s1_in_range ? count_sat : '0;
  end

endmodule
`default_nettype wire
